### src/idle_sleep_scheduler_core_defines.svh
// Assertion macros shared by the idle sleep scheduler checkers.
`ifndef IDLE_SLEEP_SCHEDULER_CORE_DEFINES_SVH
`define IDLE_SLEEP_SCHEDULER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define ISS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ISS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/iss_pkg.sv
// Types and constants shared by the idle sleep scheduler modules.
package iss_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned ApbDataW = 32;

  // Register byte address of the idle timeout (bit 2 selects the register)
  localparam logic RegIdleTimeout = 1'b0;

  // Event codes
  typedef enum logic [FuncW-1:0] {
    FN_CHECK     = 3'd0,
    FN_ACTIVITY  = 3'd1,
    FN_SET_BUSY  = 3'd2,
    FN_CLR_BUSY  = 3'd3,
    FN_ARM_AFTER = 3'd4,
    FN_CANCEL    = 3'd5,
    FN_START     = 3'd6
  } func_t;

  // One event item as held in the input register
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [TimeW-1:0] now_ms;
    logic [TimeW-1:0] delay_ms;
    logic             door_ajar;
    logic             app_allows_sleep;
  } evt_t;

  // One result item
  typedef struct packed {
    logic             sleep_request;
    logic             armed;
    logic [TimeW-1:0] deadline_ms;
    logic [TimeW-1:0] activity_ms;
  } res_t;

endpackage

### src/iss_regs.sv
// APB register block holding the idle timeout.
module iss_regs
  import iss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [TimeW-1:0]    idle_timeout_ms
);

  logic wr_hit;

  // Never wait
  assign pready = 1'b1;

  // Decode a completed write to the timeout register
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2] == RegIdleTimeout);

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ms <= '0;
    end else if (wr_hit) begin
      idle_timeout_ms <= pwdata;
    end
  end

  // Return the register, zero elsewhere
  always_comb begin
    if (paddr[2] == RegIdleTimeout) begin
      prdata = idle_timeout_ms;
    end else begin
      prdata = '0;
    end
  end

endmodule

### src/iss_engine.sv
// Event engine: deadline, activity time and busy flag with their update logic.
module iss_engine
  import iss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [TimeW-1:0] idle_timeout_ms,
  input  evt_t             evt,
  output res_t             res
);

  logic [TimeW-1:0] last_activity;
  logic [TimeW-1:0] sleep_deadline;
  logic             busy_flag;

  logic [TimeW-1:0] last_activity_next;
  logic [TimeW-1:0] sleep_deadline_next;
  logic             busy_flag_next;
  logic             req;

  logic             to_set;
  logic [TimeW-1:0] now_plus_to;
  logic [TimeW-1:0] act_plus_to;
  logic [TimeW-1:0] now_plus_delay;
  logic [TimeW-1:0] dl_eff;
  logic             allow;

  // Sums wrap at the time width
  assign to_set         = (idle_timeout_ms != '0);
  assign now_plus_to    = evt.now_ms + idle_timeout_ms;
  assign act_plus_to    = last_activity + idle_timeout_ms;
  assign now_plus_delay = evt.now_ms + evt.delay_ms;

  // Restore a disarmed deadline from the last activity before checking
  assign dl_eff = ((sleep_deadline == '0) && to_set) ? act_plus_to : sleep_deadline;
  assign allow  = !busy_flag && !evt.door_ajar && evt.app_allows_sleep;

  // Work out the state after this event
  always_comb begin
    last_activity_next  = last_activity;
    sleep_deadline_next = sleep_deadline;
    busy_flag_next      = busy_flag;
    req                 = 1'b0;
    case (func_t'(evt.func))
      FN_CHECK: begin
        sleep_deadline_next = dl_eff;
        if ((dl_eff != '0) && !(evt.now_ms < dl_eff)) begin
          if (allow) begin
            req = 1'b1;
          end else begin
            sleep_deadline_next = to_set ? now_plus_to : '0;
          end
        end
      end
      FN_ACTIVITY: begin
        last_activity_next = evt.now_ms;
        if (to_set) begin
          sleep_deadline_next = now_plus_to;
        end
      end
      FN_SET_BUSY: begin
        busy_flag_next      = 1'b1;
        sleep_deadline_next = '0;
      end
      FN_CLR_BUSY: begin
        busy_flag_next = 1'b0;
        if (to_set) begin
          sleep_deadline_next = now_plus_to;
        end
      end
      FN_ARM_AFTER: begin
        sleep_deadline_next = now_plus_delay;
      end
      FN_CANCEL: begin
        sleep_deadline_next = '0;
      end
      FN_START: begin
        last_activity_next  = evt.now_ms;
        sleep_deadline_next = now_plus_to;
        busy_flag_next      = 1'b0;
      end
      default: begin
        // Unused code: leave the state alone
      end
    endcase
  end

  // Commit the state when the item moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_activity  <= '0;
      sleep_deadline <= '0;
      busy_flag      <= 1'b0;
    end else if (en) begin
      last_activity  <= last_activity_next;
      sleep_deadline <= sleep_deadline_next;
      busy_flag      <= busy_flag_next;
    end
  end

  // Report the state after the event
  assign res.sleep_request = req;
  assign res.armed         = (sleep_deadline_next != '0);
  assign res.deadline_ms   = sleep_deadline_next;
  assign res.activity_ms   = last_activity_next;

endmodule

### src/idle_sleep_scheduler_core.sv
// Idle sleep scheduler: an inactivity timer that keeps a sleep deadline (0 means
// disarmed), the last activity time and a busy flag, and answers each event item on
// s_* with one result item on m_* showing the state after it; a check event raises
// sleep_request once now_ms has reached the deadline and nothing blocks sleep. The
// block takes one item every cycle while results are taken, and each accepted item is
// held in the input register and then passes through the event engine, whose
// 32-bit add and compare update the state as the result is loaded so the next item
// sees it at once. Results wait in an output register, and input is still taken
// while a result waits, until both registers are full. The idle timeout is written
// over the APB port at byte address 0 and should be changed only while no item is
// in flight.
module idle_sleep_scheduler_core
  import iss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Event items
  input  logic                s_tvalid,
  output logic                s_tready,
  // [31:0] now_ms, [63:32] delay_ms, [64] door_ajar, [65] app_allows_sleep, rest zero
  input  logic [InDataW-1:0]  s_tdata,
  // [2:0] func
  input  logic [FuncW-1:0]    s_tuser,
  // Result items
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] sleep_request, [1] armed, [33:2] deadline_ms, [65:34] activity_ms, rest zero
  output logic [OutDataW-1:0] m_tdata,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [TimeW-1:0] idle_timeout_ms;
  logic             in_valid;
  evt_t             in_evt;
  res_t             res;
  res_t             out_res;
  logic             out_load;

  iss_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .idle_timeout_ms (idle_timeout_ms)
  );

  // Advance when the result register is free or being emptied
  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || out_load;

  // Hold the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (out_load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_evt.func             <= s_tuser;
      in_evt.now_ms           <= s_tdata[31:0];
      in_evt.delay_ms         <= s_tdata[63:32];
      in_evt.door_ajar        <= s_tdata[64];
      in_evt.app_allows_sleep <= s_tdata[65];
    end
  end

  iss_engine u_engine (
    .clk             (clk),
    .rst             (rst),
    .en              (out_load),
    .idle_timeout_ms (idle_timeout_ms),
    .evt             (in_evt),
    .res             (res)
  );

  // Hold the result item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
  end

  // Pack the result fields
  assign m_tdata = {{(OutDataW - 2 - 2*TimeW){1'b0}}, out_res.activity_ms,
                    out_res.deadline_ms, out_res.armed, out_res.sleep_request};

endmodule

### src/iss_checker.sv
// Port-level checker for the idle sleep scheduler, bound to the top level.
`include "idle_sleep_scheduler_core_defines.svh"

module iss_checker
  import iss_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  // Armed flag must agree with the reported deadline
  `ISS_ASSERT(a_armed_matches, m_tvalid |-> (m_tdata[1] == (m_tdata[33:2] != '0)), "armed flag disagrees with deadline")

  // A sleep request only comes with an armed deadline
  `ISS_ASSERT(a_req_armed, (m_tvalid && m_tdata[0]) |-> m_tdata[1], "sleep request while disarmed")

  // Reset empties the result register
  `ISS_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result valid right after reset")

  // A stalled result stays put
  `ISS_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

endmodule

bind idle_sleep_scheduler_core iss_checker u_iss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/sv/tb.sv
// Self-checking testbench for the idle sleep scheduler core.
`timescale 1ns / 1ps

module tb;
  import iss_pkg::*;

  localparam logic [AddrW-1:0] AddrIdleTimeout = {RegIdleTimeout, 2'b00};
  localparam logic [AddrW-1:0] AddrUnmapped    = {~RegIdleTimeout, 2'b00};
  localparam logic [FuncW-1:0] FnUnused        = 3'd7;
  localparam int unsigned      StallLimit      = 1000;
  localparam int unsigned      RandomPerPhase  = 220;
  localparam int unsigned      MaxPrinted      = 50;

  // Pinned outcome for a directed item, or none
  typedef struct {
    bit   on;
    res_t val;
  } pin_t;

  // One row of the directed plan: either a register write or an event item
  typedef struct {
    bit               is_write;
    logic [AddrW-1:0] addr;
    logic [FuncW-1:0] fn;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] delay;
    logic             door;
    logic             app;
    bit               pin;
    res_t             want;
  } row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [FuncW-1:0]    s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Predictor state
  logic [TimeW-1:0] idle_to;
  logic [TimeW-1:0] last_act;
  logic [TimeW-1:0] deadline;
  logic             busy;

  res_t        outcome_q[$];
  pin_t        pinned_q[$];
  row_t        plan[$];
  int unsigned errors;
  int unsigned sent;
  int unsigned checked;
  int unsigned grants;
  int unsigned settings_run;
  bit          steady;

  idle_sleep_scheduler_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic log_mismatch(string what, logic [TimeW-1:0] got, logic [TimeW-1:0] want);
    if (errors < MaxPrinted) begin
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    end
    errors++;
  endtask

  // Apply one event to the predicted timer state and return the result it reports
  function automatic res_t advance_timer(logic [FuncW-1:0] fn, logic [TimeW-1:0] now,
                                         logic [TimeW-1:0] delay, logic door, logic app);
    res_t r;
    logic grant;
    grant = 1'b0;
    case (fn)
      FN_CHECK: begin
        if (idle_to != '0 || deadline != '0) begin
          // restore a disarmed deadline from the last activity
          if (deadline == '0) deadline = last_act + idle_to;
          if (deadline != '0 && now >= deadline) begin
            if (!busy && !door && app) grant = 1'b1;
            else deadline = (idle_to != '0) ? now + idle_to : '0;
          end
        end
      end
      FN_ACTIVITY: begin
        last_act = now;
        if (idle_to != '0) deadline = now + idle_to;
      end
      FN_SET_BUSY: begin
        busy     = 1'b1;
        deadline = '0;
      end
      FN_CLR_BUSY: begin
        busy = 1'b0;
        if (idle_to != '0) deadline = now + idle_to;
      end
      FN_ARM_AFTER: deadline = now + delay;
      FN_CANCEL:    deadline = '0;
      FN_START: begin
        last_act = now;
        deadline = now + idle_to;
        busy     = 1'b0;
      end
      default: ;
    endcase
    r.sleep_request = grant;
    r.armed         = (deadline != '0);
    r.deadline_ms   = deadline;
    r.activity_ms   = last_act;
    return r;
  endfunction

  function automatic res_t outcome(bit req, logic [TimeW-1:0] dl, logic [TimeW-1:0] act);
    res_t r;
    r.sleep_request = req;
    r.armed         = (dl != '0);
    r.deadline_ms   = dl;
    r.activity_ms   = act;
    return r;
  endfunction

  function automatic void plan_event(logic [FuncW-1:0] fn, logic [TimeW-1:0] now,
                                     logic [TimeW-1:0] delay, logic door, logic app,
                                     res_t want);
    row_t r;
    r.is_write = 1'b0;
    r.addr     = '0;
    r.fn       = fn;
    r.now      = now;
    r.delay    = delay;
    r.door     = door;
    r.app      = app;
    r.pin      = 1'b1;
    r.want     = want;
    plan.push_back(r);
  endfunction

  function automatic void plan_write(logic [AddrW-1:0] addr, logic [TimeW-1:0] val);
    row_t r;
    r.is_write = 1'b1;
    r.addr     = addr;
    r.fn       = FN_CHECK;
    r.now      = val;
    r.delay    = '0;
    r.door     = 1'b0;
    r.app      = 1'b0;
    r.pin      = 1'b0;
    r.want     = '0;
    plan.push_back(r);
  endfunction

  // Wait draw for either side: none in steady mode, else mostly short, sometimes long
  function automatic int unsigned draw_wait();
    if (steady) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  // Offer one event item and hold it until accepted
  task automatic send_event(logic [FuncW-1:0] fn, logic [TimeW-1:0] now,
                            logic [TimeW-1:0] delay, logic door, logic app,
                            bit pin, res_t want);
    int unsigned gap;
    pin_t p;
    gap = draw_wait();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p.on  = pin;
    p.val = want;
    pinned_q.push_back(p);
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {6'b0, app, door, delay, now};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outcome_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write one register, then read the timeout back
  task automatic write_register(logic [AddrW-1:0] addr, logic [TimeW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrIdleTimeout;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== idle_to) log_mismatch("idle_timeout_ms readback", prdata, idle_to);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random events around a moving timestamp so that deadlines are actually reached
  task automatic run_random(int unsigned count);
    logic [TimeW-1:0] t_now;
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] delay;
    logic [FuncW-1:0] fn;
    int unsigned      pick;
    t_now = $urandom();
    span  = (idle_to == '0) ? 64 : (idle_to > 1000) ? 2000 : idle_to * 2 + 1;
    send_event(FN_START, t_now, $urandom(), 1'b0, 1'b1, 1'b0, '0);
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      fn = FN_CHECK;
      else if (pick < 55) fn = FN_ACTIVITY;
      else if (pick < 63) fn = FN_SET_BUSY;
      else if (pick < 72) fn = FN_CLR_BUSY;
      else if (pick < 82) fn = FN_ARM_AFTER;
      else if (pick < 89) fn = FN_CANCEL;
      else if (pick < 97) fn = FN_START;
      else                fn = FnUnused;
      // advance time: small steps, a step near the timeout, no step, or a jump
      pick = $urandom_range(0, 99);
      if (pick < 65)      t_now = t_now + $urandom_range(0, span);
      else if (pick < 82) t_now = t_now + idle_to + $urandom_range(0, 2) - 1;
      else if (pick < 90) t_now = t_now;
      else if (pick < 95) t_now = '0 - idle_to;
      else                t_now = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 65)      delay = $urandom_range(0, span);
      else if (pick < 80) delay = $urandom();
      else if (pick < 87) delay = '0;
      else if (pick < 93) delay = '1;
      else                delay = '0 - t_now;
      send_event(fn, t_now, delay, $urandom_range(0, 4) == 0, $urandom_range(0, 4) != 0,
                 1'b0, '0);
      if ($urandom_range(0, 149) == 0) settle();
    end
  endtask

  // Predict on every accepted item, check every accepted result
  always @(posedge clk) begin : scoreboard
    pin_t p;
    res_t want;
    if (!rst) begin
      if (psel && penable && pwrite && pready && paddr == AddrIdleTimeout) idle_to = pwdata;
      if (s_tvalid && s_tready) begin
        want = advance_timer(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[64], s_tdata[65]);
        p.on = 1'b0;
        if (pinned_q.size() != 0) p = pinned_q.pop_front();
        if (p.on) want = p.val;
        outcome_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (outcome_q.size() == 0) begin
          log_mismatch("result with nothing pending", m_tdata[33:2], '0);
        end else begin
          want = outcome_q.pop_front();
          checked++;
          if (want.sleep_request) grants++;
          if (m_tdata[0] !== want.sleep_request)
            log_mismatch("sleep_request", m_tdata[0], want.sleep_request);
          if (m_tdata[1] !== want.armed)
            log_mismatch("armed", m_tdata[1], want.armed);
          if (m_tdata[33:2] !== want.deadline_ms)
            log_mismatch("deadline_ms", m_tdata[33:2], want.deadline_ms);
          if (m_tdata[65:34] !== want.activity_ms)
            log_mismatch("activity_ms", m_tdata[65:34], want.activity_ms);
        end
      end
    end
  end

  // Result side: stall a random number of cycles before taking each item
  initial begin : sink
    int unsigned hold;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = draw_wait();
      if (hold != 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // End the run if no handshake happens for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results pending",
             StallLimit, outcome_q.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [TimeW-1:0] settings[8];
    idle_to  = '0;
    last_act = '0;
    deadline = '0;
    busy     = 1'b0;
    errors   = 0;
    sent     = 0;
    checked  = 0;
    grants   = 0;
    settings_run = 0;
    steady   = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= FN_CHECK;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan, timeout 0 after reset
    plan_event(FN_CHECK,     32'h0,        32'h0,        1'b0, 1'b1, outcome(0, 0, 0));
    plan_event(FnUnused,     32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, outcome(0, 0, 0));
    // start with timeout 0 arms at now itself
    plan_event(FN_START,     32'h12345678, 32'h0,        1'b0, 1'b1,
               outcome(0, 32'h12345678, 32'h12345678));
    plan_event(FN_CHECK,     32'h12345677, 32'h0,        1'b0, 1'b1,
               outcome(0, 32'h12345678, 32'h12345678));
    plan_event(FN_CHECK,     32'hFFFFFFFF, 32'h0,        1'b0, 1'b1,
               outcome(1, 32'h12345678, 32'h12345678));
    // open door blocks, and with no timeout the deadline drops
    plan_event(FN_CHECK,     32'hFFFFFFFF, 32'h0,        1'b1, 1'b1,
               outcome(0, 0, 32'h12345678));
    // arm-after sum wrapping to zero stays disarmed
    plan_event(FN_ARM_AFTER, 32'hFFFFFFFF, 32'h1,        1'b0, 1'b1,
               outcome(0, 0, 32'h12345678));
    plan_event(FN_ARM_AFTER, 32'h0,        32'hFFFFFFFF, 1'b0, 1'b1,
               outcome(0, 32'hFFFFFFFF, 32'h12345678));
    plan_event(FN_SET_BUSY,  32'h0,        32'h0,        1'b0, 1'b1,
               outcome(0, 0, 32'h12345678));
    plan_event(FN_ARM_AFTER, 32'h5,        32'h5,        1'b0, 1'b1,
               outcome(0, 32'hA, 32'h12345678));
    // busy blocks sleep
    plan_event(FN_CHECK,     32'hA,        32'h0,        1'b0, 1'b1,
               outcome(0, 0, 32'h12345678));
    plan_event(FN_CLR_BUSY,  32'h3,        32'h0,        1'b0, 1'b1,
               outcome(0, 0, 32'h12345678));
    plan_event(FN_ACTIVITY,  32'hFFFFFFFF, 32'h0,        1'b0, 1'b1,
               outcome(0, 0, 32'hFFFFFFFF));
    plan_event(FN_ARM_AFTER, 32'h1,        32'h1,        1'b0, 1'b1,
               outcome(0, 32'h2, 32'hFFFFFFFF));
    plan_event(FN_CANCEL,    32'h1,        32'h0,        1'b0, 1'b1,
               outcome(0, 0, 32'hFFFFFFFF));
    // largest timeout; a write to an unmapped address must not land
    plan_write(AddrIdleTimeout, 32'hFFFFFFFF);
    plan_write(AddrUnmapped,    32'h00000055);
    plan_event(FN_CHECK,     32'h0,        32'h0,        1'b0, 1'b1,
               outcome(0, 32'hFFFFFFFE, 32'hFFFFFFFF));
    // application veto blocks and pushes the deadline back
    plan_event(FN_CHECK,     32'hFFFFFFFE, 32'h0,        1'b0, 1'b0,
               outcome(0, 32'hFFFFFFFD, 32'hFFFFFFFF));
    plan_event(FN_ACTIVITY,  32'h2,        32'h0,        1'b0, 1'b1,
               outcome(0, 32'h1, 32'h2));
    plan_event(FN_CHECK,     32'h1,        32'h0,        1'b0, 1'b1,
               outcome(1, 32'h1, 32'h2));
    plan_event(FN_SET_BUSY,  32'h1,        32'h0,        1'b0, 1'b1,
               outcome(0, 0, 32'h2));
    plan_event(FN_CLR_BUSY,  32'h1,        32'h0,        1'b0, 1'b1,
               outcome(0, 0, 32'h2));
    // disarmed deadline restored from last activity, then granted
    plan_event(FN_CHECK,     32'h5,        32'h0,        1'b0, 1'b1,
               outcome(1, 32'h1, 32'h2));
    plan_write(AddrIdleTimeout, 32'h1);
    plan_event(FN_START,     32'hFFFFFFFF, 32'h0,        1'b0, 1'b1,
               outcome(0, 0, 32'hFFFFFFFF));
    // restored deadline wraps to zero, nothing happens
    plan_event(FN_CHECK,     32'hFFFFFFFF, 32'h0,        1'b0, 1'b1,
               outcome(0, 0, 32'hFFFFFFFF));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_register(plan[i].addr, plan[i].now);
      end else begin
        send_event(plan[i].fn, plan[i].now, plan[i].delay, plan[i].door, plan[i].app,
                   plan[i].pin, plan[i].want);
      end
    end

    // Random phases over several timeouts, extremes included
    settings[0] = 32'h1;
    settings[1] = 32'd37;
    settings[2] = $urandom_range(2, 1000);
    settings[3] = 32'h0;
    settings[4] = 32'hFFFFFFFF;
    settings[5] = $urandom();
    settings[6] = 32'h80000000;
    settings[7] = 32'd5;
    foreach (settings[k]) begin
      settle();
      write_register(AddrIdleTimeout, settings[k]);
      write_register(AddrUnmapped, $urandom());
      steady = (k == 1);
      run_random(RandomPerPhase);
      settings_run++;
    end
    steady = 1'b0;
    settle();
    repeat (6) @(posedge clk);

    $display("run covered %0d event items and %0d results over %0d timeout settings,",
             sent, checked, settings_run + 3);
    $display("with %0d sleep grants and %0d mismatches", grants, errors);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
